// ----- rtl/core/rari_pkg.sv -----
// Shared types, constants and codes for the ray / axis-aligned rectangle intersection unit.
// No dependencies.
package rari_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned UV_BITS       = 16;
  localparam int unsigned CFG_IDX_W     = 3;

  // rectangle orientation; code 3 is unused and always misses
  typedef enum logic [1:0] {
    AXIS_XY = 2'd0,
    AXIS_XZ = 2'd1,
    AXIS_YZ = 2'd2
  } rari_axis_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS     = 3'd0,
    REG_OFFSET   = 3'd1,
    REG_A_LOW    = 3'd2,
    REG_A_HIGH   = 3'd3,
    REG_B_LOW    = 3'd4,
    REG_B_HIGH   = 3'd5
  } rari_reg_e;

  // ray data carried alongside the t divider
  typedef struct packed {
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic signed [31:0] org_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] t_lo;
    logic signed [31:0] t_hi;
    logic               neg;
    logic               miss;
    logic               front;
  } rari_ray_t;

  // hit data carried alongside the texture dividers
  typedef struct packed {
    logic               hit;
    logic signed [31:0] t;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               front;
    logic               zden_a;
  } rari_hit_t;

endpackage

// ----- rtl/core/rari_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// No dependencies; payload width is a parameter.
module rari_div #(
  parameter int unsigned QW = 49,   // quotient / numerator bits
  parameter int unsigned DW = 32,   // divisor bits
  parameter int unsigned PW = 1     // sideband payload bits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,      // starting remainder, below den_i
  input  logic [QW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [PW-1:0] pay_o
);

  logic          vld_q [QW];
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] num_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [PW-1:0] pay_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [QW-1:0] n_in;
    logic [DW-1:0] d_in;
    logic [PW-1:0] p_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = rem_i;
      assign n_in = num_i;
      assign d_in = den_i;
      assign p_in = pay_i;
    end else begin : g_next
      assign v_in = vld_q[k-1];
      assign r_in = rem_q[k-1];
      assign n_in = num_q[k-1];
      assign d_in = den_q[k-1];
      assign p_in = pay_q[k-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign trial = {r_in, n_in[QW-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = (trial >= {1'b0, d_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end

    // quotient bits fill the numerator register from the bottom
    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num_q[k] <= {n_in[QW-2:0], ge};
      den_q[k] <= d_in;
      pay_q[k] <= p_in;
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = num_q[QW-1];
  assign pay_o   = pay_q[QW-1];

endmodule

// ----- rtl/core/ray_axis_rect_intersect_unit.sv -----
// Ray versus axis-aligned rectangle intersection, one ray per clock.
// Depends on rari_pkg and rari_div.
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------------
//  ray in    start_i & !busy_o      origin_*_i, direction_*_i, t_lower/upper_i
//  result    done_o (one cycle)     hit_found_o, hit_t_o, tex_*_o, point_*_o,
//                                   front_face_o
//  config    cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One ray enters every clock; busy_o never rises. Each ray passes through the
// bit-per-stage t divider, stages A to C, then the two texture dividers running
// side by side, and finally the output register.
// Reset clears pipeline valid bits and loads the default rectangle.
// Results cannot be stalled, so nothing in the pipeline ever holds.
module ray_axis_rect_intersect_unit #(
  parameter int unsigned FRAC_BITS = rari_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           cfg_we_i,
  input  logic [rari_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_wdata_i,
  input  logic signed [31:0]             origin_x_i,
  input  logic signed [31:0]             origin_y_i,
  input  logic signed [31:0]             origin_z_i,
  input  logic signed [31:0]             direction_x_i,
  input  logic signed [31:0]             direction_y_i,
  input  logic signed [31:0]             direction_z_i,
  input  logic signed [31:0]             t_lower_i,
  input  logic signed [31:0]             t_upper_i,
  output logic                           done_o,
  output logic                           hit_found_o,
  output logic signed [31:0]             hit_t_o,
  output logic [16:0]                    tex_u_o,
  output logic [16:0]                    tex_v_o,
  output logic signed [31:0]             point_x_o,
  output logic signed [31:0]             point_y_o,
  output logic signed [31:0]             point_z_o,
  output logic                           front_face_o
);

  import rari_pkg::*;

  localparam int unsigned QW  = 33 + FRAC_BITS;   // t quotient bits
  localparam int unsigned TW  = QW + 1;           // signed t before range check
  localparam int unsigned PTW = 65 - FRAC_BITS;   // exact hit point bits
  localparam int unsigned UW  = UV_BITS + 1;      // texture quotient bits

  // ---------------- configuration registers ----------------
  rari_axis_e         axis_q;
  logic signed [31:0] offset_q, alo_q, ahi_q, blo_q, bhi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q   <= AXIS_XY;
      offset_q <= '0;
      alo_q    <= '0;
      ahi_q    <= 32'(1) << FRAC_BITS;
      blo_q    <= '0;
      bhi_q    <= 32'(1) << FRAC_BITS;
    end else if (cfg_we_i) begin
      unique case (rari_reg_e'(cfg_idx_i))
        REG_AXIS:   axis_q   <= rari_axis_e'(cfg_wdata_i[1:0]);
        REG_OFFSET: offset_q <= cfg_wdata_i;
        REG_A_LOW:  alo_q    <= cfg_wdata_i;
        REG_A_HIGH: ahi_q    <= cfg_wdata_i;
        REG_B_LOW:  blo_q    <= cfg_wdata_i;
        REG_B_HIGH: bhi_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // ---------------- front end: pick normal axis, set up t divide ----------------
  logic signed [31:0] org_n, dir_n;
  logic               bad_axis;
  logic signed [32:0] num;
  logic [32:0]        num_abs;
  logic [31:0]        dir_abs;
  rari_ray_t          ray_in;

  always_comb begin
    bad_axis = 1'b0;
    unique case (axis_q)
      AXIS_XY: begin
        org_n = origin_z_i;
        dir_n = direction_z_i;
      end
      AXIS_XZ: begin
        org_n = origin_y_i;
        dir_n = direction_y_i;
      end
      AXIS_YZ: begin
        org_n = origin_x_i;
        dir_n = direction_x_i;
      end
      default: begin
        org_n    = '0;
        dir_n    = '0;
        bad_axis = 1'b1;
      end
    endcase
  end

  assign num     = 33'(offset_q) - 33'(org_n);
  assign num_abs = num[32] ? 33'(-num) : num;
  assign dir_abs = dir_n[31] ? 32'(-dir_n) : dir_n;

  always_comb begin
    ray_in.org_x = origin_x_i;
    ray_in.org_y = origin_y_i;
    ray_in.org_z = origin_z_i;
    ray_in.dir_x = direction_x_i;
    ray_in.dir_y = direction_y_i;
    ray_in.dir_z = direction_z_i;
    ray_in.t_lo  = t_lower_i;
    ray_in.t_hi  = t_upper_i;
    ray_in.neg   = num[32] ^ dir_n[31];
    ray_in.miss  = bad_axis | (dir_n == '0);
    ray_in.front = dir_n[31];
  end

  logic          t_vld;
  logic [QW-1:0] t_quo;
  rari_ray_t     ray_t;

  rari_div #(
    .QW (QW),
    .DW (32),
    .PW ($bits(rari_ray_t))
  ) u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i & ~busy_o),
    .rem_i   ('0),
    .num_i   ({num_abs, FRAC_BITS'(0)}),
    .den_i   (dir_abs),
    .pay_i   (ray_in),
    .valid_o (t_vld),
    .quo_o   (t_quo),
    .pay_o   (ray_t)
  );

  // ---------------- stage A: signed t and window test ----------------
  logic signed [TW-1:0] t_mag, t_full;
  logic                 win_ok;

  assign t_mag  = $signed({1'b0, t_quo});
  assign t_full = ray_t.neg ? -t_mag : t_mag;
  assign win_ok = (t_full >= TW'(ray_t.t_lo)) && (t_full <= TW'(ray_t.t_hi));

  logic               a_vld_q, a_miss_q, a_front_q;
  logic signed [31:0] a_t_q;
  logic signed [31:0] a_org_q [3];
  logic signed [31:0] a_dir_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= t_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    a_miss_q   <= ray_t.miss | ~win_ok;
    a_front_q  <= ray_t.front;
    a_t_q      <= t_full[31:0];
    a_org_q[0] <= ray_t.org_x;
    a_org_q[1] <= ray_t.org_y;
    a_org_q[2] <= ray_t.org_z;
    a_dir_q[0] <= ray_t.dir_x;
    a_dir_q[1] <= ray_t.dir_y;
    a_dir_q[2] <= ray_t.dir_z;
  end

  // ---------------- stage B: t times direction ----------------
  logic               b_vld_q, b_miss_q, b_front_q;
  logic signed [31:0] b_t_q;
  logic signed [31:0] b_org_q  [3];
  logic signed [63:0] b_prod_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_miss_q  <= a_miss_q;
    b_front_q <= a_front_q;
    b_t_q     <= a_t_q;
    for (int k = 0; k < 3; k++) begin
      b_org_q[k]  <= a_org_q[k];
      b_prod_q[k] <= a_t_q * a_dir_q[k];
    end
  end

  // ---------------- stage C: hit point, floored ----------------
  logic signed [63:0]  prod_sh [3];
  logic signed [PTW-1:0] pt_d [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_sh[k] = b_prod_q[k] >>> FRAC_BITS;
      pt_d[k]    = PTW'(prod_sh[k]) + PTW'(b_org_q[k]);
    end
  end

  logic                  c_vld_q, c_miss_q, c_front_q;
  logic signed [31:0]    c_t_q;
  logic signed [PTW-1:0] c_pt_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_miss_q  <= b_miss_q;
    c_front_q <= b_front_q;
    c_t_q     <= b_t_q;
    for (int k = 0; k < 3; k++) begin
      c_pt_q[k] <= pt_d[k];
    end
  end

  // ---------------- stage D: bounds test, set up texture divides ----------------
  logic signed [PTW-1:0] pa, pb;
  logic                  in_rect, hit;
  logic [32:0]           diff_a, diff_b, den_a, den_b;
  logic signed [31:0]    sat_pt [3];
  rari_hit_t             hit_in;

  always_comb begin
    unique case (axis_q)
      AXIS_XY: begin
        pa = c_pt_q[0];
        pb = c_pt_q[1];
      end
      AXIS_XZ: begin
        pa = c_pt_q[0];
        pb = c_pt_q[2];
      end
      default: begin
        pa = c_pt_q[1];
        pb = c_pt_q[2];
      end
    endcase
  end

  assign in_rect = (pa >= PTW'(alo_q)) && (pa <= PTW'(ahi_q)) &&
                   (pb >= PTW'(blo_q)) && (pb <= PTW'(bhi_q));
  assign hit     = ~c_miss_q & in_rect;

  // distances stay in 0..2^32-1 whenever the point is inside
  assign diff_a = 33'(pa - PTW'(alo_q));
  assign diff_b = 33'(pb - PTW'(blo_q));
  assign den_a  = 33'(ahi_q) - 33'(alo_q);
  assign den_b  = 33'(bhi_q) - 33'(blo_q);

  // clamp the exact point to 32 bits
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (c_pt_q[k] > PTW'(32'sh7fff_ffff)) begin
        sat_pt[k] = 32'sh7fff_ffff;
      end else if (c_pt_q[k] < PTW'(-33'sh0_8000_0000)) begin
        sat_pt[k] = 32'sh8000_0000;
      end else begin
        sat_pt[k] = c_pt_q[k][31:0];
      end
    end
  end

  always_comb begin
    hit_in.hit    = hit;
    hit_in.t      = c_t_q;
    hit_in.px     = sat_pt[0];
    hit_in.py     = sat_pt[1];
    hit_in.pz     = sat_pt[2];
    hit_in.front  = c_front_q;
    hit_in.zden_a = (den_a == '0);
  end

  // quotient never exceeds 2^UV_BITS, so start with the top bits preloaded
  logic          u_vld, v_vld, zden_b;
  logic [UW-1:0] u_quo, v_quo;
  rari_hit_t     hit_out;

  rari_div #(
    .QW (UW),
    .DW (33),
    .PW ($bits(rari_hit_t))
  ) u_div_u (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_vld_q),
    .rem_i   ({1'b0, diff_a[32:1]}),
    .num_i   ({diff_a[0], UV_BITS'(0)}),
    .den_i   (den_a),
    .pay_i   (hit_in),
    .valid_o (u_vld),
    .quo_o   (u_quo),
    .pay_o   (hit_out)
  );

  rari_div #(
    .QW (UW),
    .DW (33),
    .PW (1)
  ) u_div_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_vld_q),
    .rem_i   ({1'b0, diff_b[32:1]}),
    .num_i   ({diff_b[0], UV_BITS'(0)}),
    .den_i   (den_b),
    .pay_i   (den_b == '0),
    .valid_o (v_vld),
    .quo_o   (v_quo),
    .pay_o   (zden_b)
  );

  // ---------------- output register, zeros on a miss ----------------
  logic               done_q, hit_q, front_q;
  logic signed [31:0] t_q, px_q, py_q, pz_q;
  logic [16:0]        u_q, v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= u_vld & v_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= hit_out.hit;
    t_q     <= hit_out.hit ? hit_out.t : '0;
    px_q    <= hit_out.hit ? hit_out.px : '0;
    py_q    <= hit_out.hit ? hit_out.py : '0;
    pz_q    <= hit_out.hit ? hit_out.pz : '0;
    front_q <= hit_out.hit & hit_out.front;
    u_q     <= (hit_out.hit && !hit_out.zden_a) ? 17'(u_quo) : '0;
    v_q     <= (hit_out.hit && !zden_b) ? 17'(v_quo) : '0;
  end

  assign done_o       = done_q;
  assign hit_found_o  = hit_q;
  assign hit_t_o      = t_q;
  assign tex_u_o      = u_q;
  assign tex_v_o      = v_q;
  assign point_x_o    = px_q;
  assign point_y_o    = py_q;
  assign point_z_o    = pz_q;
  assign front_face_o = front_q;

endmodule
